[hw/rtl/lfic_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfic_pkg: shared types and constants for the legacy float converter
// Mode and status codes, exponent rebias constants and byte swap helpers.
// ----------------------------------------------------------------------------
package lfic_pkg;

  typedef enum logic [1:0] {
    MODE_L64_TO_DBL = 2'd0,
    MODE_DBL_TO_L64 = 2'd1,
    MODE_L32_TO_SGL = 2'd2,
    MODE_SGL_TO_L32 = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;

  localparam logic [10:0] DBL_REBIAS  = 11'd767;
  localparam logic [10:0] DBL_EXP_MAX = 11'd1278;
  localparam logic [8:0]  SGL_REBIAS  = 9'd129;
  localparam logic [8:0]  SGL_EXP_MAX = 9'd382;

  function automatic logic [WORD_W-1:0] swap64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [HALF_W-1:0] swap32(input logic [HALF_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/legacy_float_ieee_converter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// legacy_float_ieee_converter_top: legacy float / IEEE 754 word converter
// Input register, conversion logic and result register with stall flow.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low: the word is captured in an
// input register, converted by one pass of repacking logic (one exponent add
// and its range compares) and held in a result register. The input register
// keeps accepting while a result waits on a stalled output; in_stall rises
// only when both registers are full and out_stall is high.
module legacy_float_ieee_converter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lfic_pkg::mode_t     in_mode,
  input  logic [63:0]         in_buffer_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_buffer_out,
  output lfic_pkg::status_t   out_status
);
  import lfic_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  mode_t       s1_mode_r;
  logic [63:0] s1_buf_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_buf_r;
  status_t     out_status_r;
  logic [63:0] conv_buf;
  status_t     conv_status;
  logic        in_take;
  logic        s1_adv;

  lfic_conv u_conv (
    .mode    (s1_mode_r),
    .buf_in  (s1_buf_r),
    .buf_out (conv_buf),
    .status  (conv_status)
  );

  always_comb begin
    in_stall      = s1_valid_r && out_valid_r && out_stall;
    in_take       = in_valid && !in_stall;
    s1_adv        = s1_valid_r && !(out_valid_r && out_stall);
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r <= in_mode;
      s1_buf_r  <= in_buffer_in;
    end
    if (s1_adv) begin
      out_buf_r    <= conv_buf;
      out_status_r <= conv_status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_buffer_out = out_buf_r;
  assign out_status     = out_status_r;

`ifndef SYNTHESIS
  a_fault_modes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && conv_status != ST_OK |->
      s1_mode_r == MODE_DBL_TO_L64 || s1_mode_r == MODE_L32_TO_SGL)
    else $error("range fault in a mode that cannot fault");

  a_half_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (s1_mode_r == MODE_L32_TO_SGL || s1_mode_r == MODE_SGL_TO_L32) |->
      conv_buf[63:32] == 32'd0)
    else $error("32-bit mode result has upper bits set");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r && $stable(s1_buf_r))
    else $error("input register dropped a word under stall");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free register");
`endif

endmodule
`default_nettype wire

[hw/rtl/lfic_conv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfic_conv: one-word format conversion
// Rebias the exponent, truncate or pad the mantissa, reverse byte order and
// flag exponent range faults for one buffer word.
// ----------------------------------------------------------------------------
module lfic_conv (
  input  lfic_pkg::mode_t         mode,
  input  logic [63:0]             buf_in,
  output logic [63:0]             buf_out,
  output lfic_pkg::status_t       status
);
  import lfic_pkg::*;

  logic [8:0]  l64_exp;
  logic [10:0] l64_dexp;
  logic [63:0] l64_dbl;
  logic [63:0] dbl_word;
  logic [10:0] dbl_exp;
  logic [10:0] dbl_lexp;
  logic [31:0] l32_word;
  logic [8:0]  l32_exp;
  logic [8:0]  l32_sexp;
  logic [31:0] l32_sgl;
  logic [31:0] sgl_word;
  logic [7:0]  sgl_exp;
  logic [8:0]  sgl_lexp;

  always_comb begin
    l64_exp  = buf_in[8:0];
    l64_dexp = {2'b00, l64_exp} + DBL_REBIAS;
    l64_dbl  = {buf_in[63], l64_dexp, buf_in[62:11]};

    dbl_word = swap64(buf_in);
    dbl_exp  = dbl_word[62:52];
    dbl_lexp = dbl_exp - DBL_REBIAS;

    l32_word = buf_in[31:0];
    l32_exp  = l32_word[8:0];
    l32_sexp = l32_exp - SGL_REBIAS;
    l32_sgl  = {l32_word[31], l32_sexp[7:0], l32_word[30:9], 1'b0};

    sgl_word = swap32(buf_in[31:0]);
    sgl_exp  = sgl_word[30:23];
    sgl_lexp = {1'b0, sgl_exp} + SGL_REBIAS;
  end

  always_comb begin
    buf_out = buf_in;
    status  = ST_OK;
    case (mode)
      MODE_L64_TO_DBL: begin
        if (l64_exp != 9'd0) begin
          buf_out = swap64(l64_dbl);
        end
      end
      MODE_DBL_TO_L64: begin
        buf_out = dbl_word;
        if (dbl_exp == 11'd0) begin
          status = ST_OK;
        end else if (dbl_exp < DBL_REBIAS) begin
          status = ST_UNDER;
        end else if (dbl_exp > DBL_EXP_MAX) begin
          status = ST_OVER;
        end else begin
          buf_out = {dbl_word[63], dbl_word[51:0], 2'b00, dbl_lexp[8:0]};
        end
      end
      MODE_L32_TO_SGL: begin
        buf_out = {32'd0, l32_word};
        if (l32_exp == 9'd0) begin
          status = ST_OK;
        end else if (l32_exp < SGL_REBIAS) begin
          status = ST_UNDER;
        end else if (l32_exp > SGL_EXP_MAX) begin
          status = ST_OVER;
        end else begin
          buf_out = {32'd0, swap32(l32_sgl)};
        end
      end
      MODE_SGL_TO_L32: begin
        buf_out = {32'd0, sgl_word};
        if (sgl_exp != 8'd0) begin
          buf_out = {32'd0, sgl_word[31], sgl_word[22:1], sgl_lexp};
        end
      end
      default: begin
        buf_out = buf_in;
        status  = ST_OK;
      end
    endcase
  end

endmodule
`default_nettype wire

[bench/legacy_float_ieee_converter_top_tb.sv]
// ----------------------------------------------------------------------------
// legacy_float_ieee_converter_top_tb: self-checking bench for the converter
// Drives words in all four conversion directions through the valid/stall
// channels with random gaps and backpressure. Each accepted word is predicted
// into an expected buffer and status. Each result word is compared in order.
// ----------------------------------------------------------------------------
module legacy_float_ieee_converter_top_tb;
  import lfic_pkg::*;

  localparam int EXP_SHIFT_64     = 767;
  localparam int EXP_LIMIT_64     = 1278;
  localparam int EXP_SHIFT_32     = 129;
  localparam int EXP_LIMIT_32     = 382;
  localparam int RANDOM_WORDS     = 1250;
  localparam int BURST_WORDS      = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 8;

  typedef struct packed {
    logic [63:0] buffer;
    status_t     status;
  } conv_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  mode_t       in_mode;
  logic [63:0] in_buffer_in;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_buffer_out;
  status_t     out_status;

  conv_result_t expected_words[$];
  int           error_count = 0;
  int           results_checked = 0;
  int           words_per_mode[4] = '{0, 0, 0, 0};
  int           status_seen[4] = '{0, 0, 0, 0};
  int           input_held_cycles = 0;
  int           quiet_cycles = 0;
  logic         idle_enable = 1'b1;
  logic         hold_output = 1'b0;

  legacy_float_ieee_converter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_buffer_in  (in_buffer_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_buffer_out(out_buffer_out),
    .out_status    (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] byte_rev64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  function automatic logic [31:0] byte_rev32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic conv_result_t predict_conversion(input mode_t m, input logic [63:0] b);
    conv_result_t r;
    logic [63:0]  dbl;
    logic [31:0]  half;
    logic [10:0]  dexp;
    logic [8:0]   lexp;
    logic [7:0]   sexp;
    r.status = ST_OK;
    case (m)
      MODE_L64_TO_DBL: begin
        lexp = b[8:0];
        dexp = 11'(lexp + EXP_SHIFT_64);
        r.buffer = (lexp == 9'd0) ? b : byte_rev64({b[63], dexp, b[62:11]});
      end
      MODE_DBL_TO_L64: begin
        dbl = byte_rev64(b);
        dexp = dbl[62:52];
        r.buffer = dbl;
        if (dexp != 11'd0) begin
          if (dexp < EXP_SHIFT_64) begin
            r.status = ST_UNDER;
          end else if (dexp > EXP_LIMIT_64) begin
            r.status = ST_OVER;
          end else begin
            lexp = 9'(dexp - EXP_SHIFT_64);
            r.buffer = {dbl[63], dbl[51:0], 2'b00, lexp};
          end
        end
      end
      MODE_L32_TO_SGL: begin
        half = b[31:0];
        lexp = half[8:0];
        r.buffer = {32'd0, half};
        if (lexp != 9'd0) begin
          if (lexp < EXP_SHIFT_32) begin
            r.status = ST_UNDER;
          end else if (lexp > EXP_LIMIT_32) begin
            r.status = ST_OVER;
          end else begin
            sexp = 8'(lexp - EXP_SHIFT_32);
            r.buffer = {32'd0, byte_rev32({half[31], sexp, half[30:9], 1'b0})};
          end
        end
      end
      default: begin
        half = byte_rev32(b[31:0]);
        sexp = half[30:23];
        r.buffer = {32'd0, half};
        if (sexp != 8'd0) begin
          lexp = 9'(sexp + EXP_SHIFT_32);
          r.buffer = {32'd0, half[31], half[22:1], lexp};
        end
      end
    endcase
    return r;
  endfunction

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enable || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] random_buffer(input mode_t m);
    logic [63:0] b;
    logic [63:0] dbl;
    logic [31:0] half;
    int          pick;
    b = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    case (m)
      MODE_L64_TO_DBL: begin
        if (pick < 10) b[8:0] = 9'd0;
      end
      MODE_DBL_TO_L64: begin
        dbl = b;
        if (pick < 60) begin
          dbl[62:52] = 11'($urandom_range(EXP_SHIFT_64, EXP_LIMIT_64));
        end else if (pick < 75) begin
          case ($urandom_range(0, 5))
            0: dbl[62:52] = 11'd0;
            1: dbl[62:52] = 11'(EXP_SHIFT_64 - 1);
            2: dbl[62:52] = 11'(EXP_SHIFT_64);
            3: dbl[62:52] = 11'(EXP_LIMIT_64);
            4: dbl[62:52] = 11'(EXP_LIMIT_64 + 1);
            default: dbl[62:52] = 11'h7FF;
          endcase
        end
        b = byte_rev64(dbl);
      end
      MODE_L32_TO_SGL: begin
        if (pick < 60) begin
          b[8:0] = 9'($urandom_range(EXP_SHIFT_32, EXP_LIMIT_32));
        end else if (pick < 75) begin
          case ($urandom_range(0, 5))
            0: b[8:0] = 9'd0;
            1: b[8:0] = 9'(EXP_SHIFT_32 - 1);
            2: b[8:0] = 9'(EXP_SHIFT_32);
            3: b[8:0] = 9'(EXP_LIMIT_32);
            4: b[8:0] = 9'(EXP_LIMIT_32 + 1);
            default: b[8:0] = 9'h1FF;
          endcase
        end
      end
      default: begin
        half = b[31:0];
        if (pick < 10) half[30:23] = 8'd0;
        b[31:0] = byte_rev32(half);
      end
    endcase
    return b;
  endfunction

  // call at a falling edge; returns at a falling edge
  task automatic send_word(input mode_t m, input logic [63:0] b);
    int gap;
    in_mode = m;
    in_buffer_in = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_conversion(m, b));
    words_per_mode[int'(m)]++;
    @(negedge clk);
    gap = idle_length();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin : drive_out_stall
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_output = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        stall_left = idle_length();
        out_stall = (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    conv_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: buffer_out=%h status=%0d",
               out_buffer_out, out_status);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_buffer_out !== want.buffer) begin
          $error("buffer_out mismatch: expected %h, actual %h", want.buffer, out_buffer_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
          error_count++;
        end
        results_checked++;
        status_seen[int'(want.status)]++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_corner_words();
    send_word(MODE_L64_TO_DBL, 64'h0);
    send_word(MODE_L64_TO_DBL, 64'hFFFF_FFFF_FFFF_FE00);
    send_word(MODE_L64_TO_DBL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(MODE_L64_TO_DBL, 64'h8000_0000_0000_0001);
    send_word(MODE_L64_TO_DBL, 64'h4000_0000_0000_0601);

    send_word(MODE_DBL_TO_L64, byte_rev64({1'b1, 11'd0, 52'hF_FFFF_FFFF_FFFF}));
    send_word(MODE_DBL_TO_L64, byte_rev64({1'b0, 11'd766, 52'hA_5A5A_5A5A_5A5A}));
    send_word(MODE_DBL_TO_L64, byte_rev64({1'b1, 11'd767, 52'h0}));
    send_word(MODE_DBL_TO_L64, byte_rev64({1'b0, 11'd1278, 52'hF_FFFF_FFFF_FFFF}));
    send_word(MODE_DBL_TO_L64, byte_rev64({1'b1, 11'd1279, 52'h0}));
    send_word(MODE_DBL_TO_L64, 64'hFFFF_FFFF_FFFF_FFFF);

    send_word(MODE_L32_TO_SGL, {32'hFFFF_FFFF, 32'h7FFF_FE00});
    send_word(MODE_L32_TO_SGL, {32'h0, 1'b1, 22'h3F_FFFF, 9'd128});
    send_word(MODE_L32_TO_SGL, {32'hFFFF_FFFF, 1'b0, 22'h0, 9'd129});
    send_word(MODE_L32_TO_SGL, {32'h0, 1'b1, 22'h3F_FFFF, 9'd382});
    send_word(MODE_L32_TO_SGL, {32'h0, 1'b0, 22'h15_5555, 9'd383});
    send_word(MODE_L32_TO_SGL, 64'hFFFF_FFFF_FFFF_FFFF);

    send_word(MODE_SGL_TO_L32, {32'hFFFF_FFFF, byte_rev32({1'b1, 8'd0, 23'h7F_FFFF})});
    send_word(MODE_SGL_TO_L32, {32'h0, byte_rev32({1'b0, 8'd1, 23'h00_0001})});
    send_word(MODE_SGL_TO_L32, {32'h0, byte_rev32({1'b1, 8'd255, 23'h7F_FFFF})});
    send_word(MODE_SGL_TO_L32, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_words();
    mode_t m;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      m = mode_t'($urandom_range(0, 3));
      send_word(m, random_buffer(m));
    end
  endtask

  task automatic test_back_to_back();
    mode_t m;
    idle_enable = 1'b0;
    for (int i = 0; i < BURST_WORDS; i++) begin
      m = mode_t'($urandom_range(0, 3));
      send_word(m, random_buffer(m));
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_output_backpressure();
    mode_t m;
    idle_enable = 1'b0;
    hold_output = 1'b1;
    for (int i = 0; i < 40; i++) begin
      m = mode_t'($urandom_range(0, 3));
      send_word(m, random_buffer(m));
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_L64_TO_DBL;
    in_buffer_in = 64'd0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_corner_words();
    test_output_backpressure();
    test_random_words();
    test_back_to_back();

    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d result words over %0d/%0d/%0d/%0d input words per direction",
             results_checked, words_per_mode[0], words_per_mode[1],
             words_per_mode[2], words_per_mode[3]);
    $display("Status ok/underflow/overflow %0d/%0d/%0d; input stalled %0d cycles",
             status_seen[0], status_seen[1], status_seen[2], input_held_cycles);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
